/* hw/rtl/mrht_pkg.sv */
// Package for the multi-room hysteresis thermostat.
// Holds the item structs, configuration types, register indexes and constants.
// No dependencies.
package mrht_pkg;

  localparam int unsigned ROOMS     = 6;
  localparam int unsigned ROOM_W    = 3;
  localparam int unsigned TEMP_BITS = 12;
  localparam int unsigned MARGIN_W  = 9;
  localparam int unsigned CNT_W     = 9;
  localparam int unsigned CFG_IDX_W = 3;

  // tick counter wrap point
  localparam logic [CNT_W-1:0] INTERVAL = 9'd256;

  // sample window, exclusive at both ends (sixteenths of a degree)
  localparam logic signed [TEMP_BITS:0] LOW_LIMIT  = 13'sd0;
  localparam logic signed [TEMP_BITS:0] HIGH_LIMIT = 13'sd800;

  localparam logic signed [TEMP_BITS-1:0] TARGET_RESET = 12'sd320;
  localparam logic [MARGIN_W-1:0]         MARGIN_RESET = 9'd16;

  typedef logic signed [TEMP_BITS-1:0] temp_t;

  // item kinds
  typedef enum logic {
    KIND_TICK   = 1'b0,
    KIND_SAMPLE = 1'b1
  } kind_e;

  // configuration register indexes
  typedef enum logic [CFG_IDX_W-1:0] {
    CFG_TARGET_0 = 3'd0,
    CFG_TARGET_1 = 3'd1,
    CFG_TARGET_2 = 3'd2,
    CFG_TARGET_3 = 3'd3,
    CFG_TARGET_4 = 3'd4,
    CFG_TARGET_5 = 3'd5,
    CFG_MARGIN   = 3'd6,
    CFG_AUTO     = 3'd7
  } cfg_idx_e;

  typedef struct packed {
    logic                kind;
    logic [ROOM_W-1:0]   room;
    logic [TEMP_BITS-1:0] temperature;
  } in_item_t;

  typedef struct packed {
    logic [ROOMS-1:0] radiator_mask;
    logic             read_request;
    logic             sample_accepted;
  } out_item_t;

  typedef struct packed {
    temp_t [ROOMS-1:0]   target;
    logic [MARGIN_W-1:0] margin;
    logic                auto_enable;
  } cfg_t;

endpackage

/* hw/rtl/multi_room_hysteresis_thermostat.sv */
// Top level of the six-room hysteresis thermostat.
// Depends on mrht_pkg, mrht_timer and mrht_rooms.
//
// Usage:
//   Input channel (in_valid_i / in_stall_o / in_data_i) carries one request
//   per item: a tick (kind 0) or a sensor sample (kind 1, room, temperature).
//   Output channel (out_valid_o / out_stall_i / out_data_o) returns exactly
//   one result per request: radiator mask after the update, read request
//   and sample-accepted flag.
//   A request is taken into an input register; it is evaluated against
//   the room state once the output register is free or being drained,
//   and its result lands in the output register.
//   Throughput: one request per cycle while the receiver does not stall,
//   set by the single evaluation pass of the six room comparators and the
//   two counters.
//   When the receiver stalls, the output register holds its result and the
//   input register holds the pending request; in_stall_o rises only when
//   both are full, so one further request is still taken.
//   Configuration: cfg_we_i writes register cfg_idx_i with cfg_data_i;
//   write only while no request is in flight.
//   Reset: targets 320, margin 16, automatic mode off, counters and stored
//   temperatures zero, all radiators off, both registers empty.
module multi_room_hysteresis_thermostat (
  input  logic                clk_i,
  input  logic                rst_ni,
  input  logic                in_valid_i,
  output logic                in_stall_o,
  input  mrht_pkg::in_item_t  in_data_i,
  output logic                out_valid_o,
  input  logic                out_stall_i,
  output mrht_pkg::out_item_t out_data_o,
  input  logic                cfg_we_i,
  input  logic [mrht_pkg::CFG_IDX_W-1:0] cfg_idx_i,
  input  logic [mrht_pkg::TEMP_BITS-1:0] cfg_data_i
);
  import mrht_pkg::*;

  cfg_t      cfg_q;
  logic      s1_valid_q;
  in_item_t  s1_data_q;
  logic      out_valid_q;
  out_item_t out_data_q;

  logic             advance;
  logic             accept;
  logic             tick;
  logic             req;
  logic             acc;
  logic [ROOMS-1:0] mask;

  // configuration registers
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      for (int r = 0; r < ROOMS; r++) cfg_q.target[r] <= TARGET_RESET;
      cfg_q.margin      <= MARGIN_RESET;
      cfg_q.auto_enable <= 1'b0;
    end else if (cfg_we_i) begin
      case (cfg_idx_i) inside
        [CFG_TARGET_0:CFG_TARGET_5]: cfg_q.target[cfg_idx_i] <= cfg_data_i;
        CFG_MARGIN:                  cfg_q.margin <= cfg_data_i[MARGIN_W-1:0];
        CFG_AUTO:                    cfg_q.auto_enable <= cfg_data_i[0];
        default: ;
      endcase
    end
  end

  // handshake: evaluate when the output register is free or being drained
  always_comb begin
    advance    = s1_valid_q && (!out_valid_q || !out_stall_i);
    in_stall_o = s1_valid_q && !advance;
    accept     = in_valid_i && !in_stall_o;
    tick       = advance && (s1_data_q.kind == KIND_TICK);
  end

  mrht_timer u_timer (
    .clk_i  (clk_i),
    .rst_ni (rst_ni),
    .tick_i (tick),
    .req_o  (req)
  );

  mrht_rooms u_rooms (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .upd_i      (advance),
    .item_i     (s1_data_q),
    .cfg_i      (cfg_q),
    .mask_o     (mask),
    .accepted_o (acc)
  );

  // input and result registers
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      s1_valid_q  <= 1'b0;
      out_valid_q <= 1'b0;
    end else begin
      if (accept) begin
        s1_valid_q <= 1'b1;
      end else if (advance) begin
        s1_valid_q <= 1'b0;
      end
      if (advance) begin
        out_valid_q <= 1'b1;
      end else if (!out_stall_i) begin
        out_valid_q <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (accept) begin
      s1_data_q <= in_data_i;
    end
    if (advance) begin
      out_data_q.radiator_mask   <= mask;
      out_data_q.read_request    <= req;
      out_data_q.sample_accepted <= acc && (s1_data_q.kind == KIND_SAMPLE);
    end
  end

  assign out_valid_o = out_valid_q;
  assign out_data_o  = out_data_q;

  // a result never claims both a read request and a stored sample
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o |-> !(out_data_o.read_request && out_data_o.sample_accepted))
    else $error("result has both read request and sample accepted");

  // a pending request with a stalled full output must back-pressure
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    (s1_valid_q && out_valid_q && out_stall_i) |-> in_stall_o)
    else $error("input not stalled while both registers are held");

endmodule

/* hw/rtl/mrht_timer.sv */
// Tick timer of the thermostat: two chained counters that raise a read request.
// Depends on mrht_pkg.
module mrht_timer (
  input  logic clk_i,
  input  logic rst_ni,
  input  logic tick_i,
  output logic req_o
);
  import mrht_pkg::*;

  logic [CNT_W-1:0] fast_q, fast_d;
  logic [CNT_W-1:0] slow_q, slow_d;

  // next counts; request when both wrap on the same tick
  always_comb begin
    fast_d = fast_q;
    slow_d = slow_q;
    req_o  = 1'b0;
    if (tick_i) begin
      if (fast_q >= INTERVAL) begin
        fast_d = '0;
        if (slow_q >= INTERVAL) begin
          slow_d = '0;
          req_o  = 1'b1;
        end else begin
          slow_d = slow_q + 1'b1;
        end
      end else begin
        fast_d = fast_q + 1'b1;
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      fast_q <= '0;
      slow_q <= '0;
    end else begin
      fast_q <= fast_d;
      slow_q <= slow_d;
    end
  end

  // a request only ever comes with both counters at their wrap point
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    req_o |-> (fast_q == INTERVAL && slow_q == INTERVAL))
    else $error("read request without both counters wrapping");

  // slow counter only moves on a fast wrap
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    (tick_i && fast_q < INTERVAL) |=> $stable(slow_q))
    else $error("slow counter moved without a fast wrap");

endmodule

/* hw/rtl/mrht_rooms.sv */
// Per-room sample store and hysteresis comparators of the thermostat.
// Depends on mrht_pkg.
module mrht_rooms (
  input  logic               clk_i,
  input  logic               rst_ni,
  input  logic               upd_i,
  input  mrht_pkg::in_item_t item_i,
  input  mrht_pkg::cfg_t     cfg_i,
  output logic [mrht_pkg::ROOMS-1:0] mask_o,
  output logic               accepted_o
);
  import mrht_pkg::*;

  temp_t [ROOMS-1:0] temp_q, temp_d;
  logic  [ROOMS-1:0] rad_q, rad_d;

  logic signed [TEMP_BITS:0] sample_ext;
  logic                      in_window;
  logic                      is_sample;

  // window check on the incoming sample
  always_comb begin
    is_sample  = (item_i.kind == KIND_SAMPLE);
    sample_ext = {item_i.temperature[TEMP_BITS-1], item_i.temperature};
    in_window  = (sample_ext > LOW_LIMIT) && (sample_ext < HIGH_LIMIT);
    accepted_o = is_sample && in_window && (item_i.room < ROOM_W'(ROOMS));
  end

  // store, then compare each room against its target
  always_comb begin
    logic signed [TEMP_BITS+1:0] t_ext;
    logic signed [TEMP_BITS+1:0] tgt_ext;
    logic signed [TEMP_BITS+1:0] hi_ext;
    temp_d = temp_q;
    rad_d  = rad_q;
    t_ext   = '0;
    tgt_ext = '0;
    hi_ext  = '0;
    for (int r = 0; r < ROOMS; r++) begin
      if (accepted_o && item_i.room == ROOM_W'(r)) begin
        temp_d[r] = item_i.temperature;
      end
      t_ext   = {{2{temp_d[r][TEMP_BITS-1]}}, temp_d[r]};
      tgt_ext = {{2{cfg_i.target[r][TEMP_BITS-1]}}, cfg_i.target[r]};
      hi_ext  = tgt_ext + $signed({5'b0, cfg_i.margin});
      if (cfg_i.auto_enable) begin
        if (!rad_q[r]) begin
          if (t_ext <= tgt_ext) rad_d[r] = 1'b1;
        end else begin
          if (t_ext > hi_ext) rad_d[r] = 1'b0;
        end
      end
    end
    mask_o = rad_d;
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      temp_q <= '0;
      rad_q  <= '0;
    end else if (upd_i) begin
      temp_q <= temp_d;
      rad_q  <= rad_d;
    end
  end

  // radiators hold while automatic switching is off
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    !cfg_i.auto_enable |=> $stable(rad_q))
    else $error("radiator changed with automatic mode off");

  // a tick never touches the stored temperatures
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    (upd_i && item_i.kind == KIND_TICK) |=> $stable(temp_q))
    else $error("temperature store written on a tick");

endmodule

/* tb/sv/multi_room_hysteresis_thermostat_tb.sv */
`timescale 1ns / 1ps
// Self-checking testbench for the multi-room hysteresis thermostat.
// Drives ticks and sensor samples against a cycle-free predictor and checks every result.
// Depends on mrht_pkg and multi_room_hysteresis_thermostat.
module multi_room_hysteresis_thermostat_tb;
  import mrht_pkg::*;

  // cycles with no handshake on either channel before the run is abandoned;
  // the longest legitimate quiet stretch is a sender gap or a settings write
  localparam int unsigned QUIET_LIMIT = 2000;
  localparam int unsigned PHASE_ITEMS = 65;
  localparam int unsigned PHASES      = 6;
  localparam int unsigned TICK_RUN    = 40;
  localparam int unsigned IN_W        = $bits(in_item_t);

  logic                 clk_i;
  logic                 rst_ni      = 1'b0;
  logic                 in_valid_i  = 1'b0;
  logic                 in_stall_o;
  in_item_t             in_data_i   = '0;
  logic                 out_valid_o;
  logic                 out_stall_i = 1'b0;
  out_item_t            out_data_o;
  logic                 cfg_we_i    = 1'b0;
  logic [CFG_IDX_W-1:0] cfg_idx_i   = '0;
  logic [TEMP_BITS-1:0] cfg_data_i  = '0;

  multi_room_hysteresis_thermostat u_top (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .in_valid_i  (in_valid_i),
    .in_stall_o  (in_stall_o),
    .in_data_i   (in_data_i),
    .out_valid_o (out_valid_o),
    .out_stall_i (out_stall_i),
    .out_data_o  (out_data_o),
    .cfg_we_i    (cfg_we_i),
    .cfg_idx_i   (cfg_idx_i),
    .cfg_data_i  (cfg_data_i)
  );

  // thermostat state as the predictor sees it
  temp_t                room_target [ROOMS];
  logic [MARGIN_W-1:0]  hyst_margin;
  logic                 auto_mode;
  int unsigned          fast_cnt;
  int unsigned          slow_cnt;
  temp_t                stored_temp [ROOMS];
  logic [ROOMS-1:0]     heat_on;

  // staged targets for the next settings write
  temp_t                staged_target [ROOMS];

  out_item_t            expected_results [$];

  int unsigned mismatch_count;
  int unsigned requests_sent;
  int unsigned samples_stored;
  int unsigned read_requests_seen;
  int unsigned radiator_switches;
  int unsigned settings_applied;
  int unsigned quiet_cycles;

  // idling controls
  bit          send_idling;
  bit          stall_idling;
  int unsigned burst_left;
  bit          stall_now;
  int unsigned stall_run;

  initial begin
    clk_i = 1'b0;
    forever #10 clk_i = ~clk_i;
  end

  // Predictor: one tick or sample in, one result out
  task automatic thermostat_predict(input in_item_t req, output out_item_t res);
    int               t;
    logic [ROOMS-1:0] prev_mask;
    res       = '0;
    t         = int'(temp_t'(req.temperature));
    prev_mask = heat_on;
    if (req.kind == KIND_TICK) begin
      if (fast_cnt >= INTERVAL) begin
        fast_cnt = 0;
        if (slow_cnt >= INTERVAL) begin
          slow_cnt = 0;
          res.read_request = 1'b1;
        end else begin
          slow_cnt++;
        end
      end else begin
        fast_cnt++;
      end
    end else if (req.room < ROOMS && t > LOW_LIMIT && t < HIGH_LIMIT) begin
      stored_temp[req.room] = temp_t'(req.temperature);
      res.sample_accepted   = 1'b1;
    end
    // hysteresis update, after this request's sample is in place
    if (auto_mode) begin
      for (int r = 0; r < ROOMS; r++) begin
        if (!heat_on[r]) begin
          if (int'(stored_temp[r]) <= int'(room_target[r])) heat_on[r] = 1'b1;
        end else begin
          if (int'(stored_temp[r]) > int'(room_target[r]) + int'(hyst_margin)) heat_on[r] = 1'b0;
        end
      end
    end
    res.radiator_mask = heat_on;
    radiator_switches += $countones(prev_mask ^ heat_on);
    if (res.sample_accepted) samples_stored++;
    if (res.read_request) read_requests_seen++;
  endtask

  // Send one request; returns at the edge where it was taken, or after a sender gap behind it
  task automatic send_request(input in_item_t req);
    out_item_t res;
    int unsigned gap;
    in_valid_i <= 1'b1;
    in_data_i  <= req;
    do @(posedge clk_i); while (in_stall_o);
    thermostat_predict(req, res);
    expected_results.push_back(res);
    requests_sent++;
    if (send_idling) begin
      if (burst_left == 0) begin
        burst_left = $urandom_range(0, 24);
        gap        = $urandom_range(1, 7);
        in_valid_i <= 1'b0;
        repeat (gap) @(posedge clk_i);
      end else begin
        burst_left--;
      end
    end
  endtask

  function automatic in_item_t make_sample(int unsigned room, int temp);
    in_item_t req;
    req.kind        = KIND_SAMPLE;
    req.room        = room[ROOM_W-1:0];
    req.temperature = temp[TEMP_BITS-1:0];
    return req;
  endfunction

  // tick with junk in the fields that a tick ignores
  function automatic in_item_t make_tick();
    in_item_t req;
    req             = in_item_t'(IN_W'($urandom));
    req.kind        = KIND_TICK;
    return req;
  endfunction

  // Mostly samples, many around each room's switching band, plus ticks and noise
  function automatic in_item_t random_request();
    in_item_t    req;
    int unsigned sel;
    int unsigned room;
    int          temp;
    sel = $urandom_range(0, 99);
    if (sel < 25) begin
      req = make_tick();
    end else if (sel < 80) begin
      room = $urandom_range(0, ROOMS - 1);
      if ($urandom_range(0, 9) < 3) begin
        temp = int'($urandom_range(1, 799));
      end else begin
        temp = int'(room_target[room]) - 24 +
               int'($urandom_range(0, int'(hyst_margin) + 48));
      end
      req = make_sample(room, temp);
    end else begin
      req      = in_item_t'(IN_W'($urandom));
      req.kind = KIND_SAMPLE;
    end
    return req;
  endfunction

  // Hold off the sender until every result is back
  task automatic drain_results();
    if (in_valid_i) in_valid_i <= 1'b0;
    while (expected_results.size() != 0) @(posedge clk_i);
  endtask

  task automatic cfg_write(input cfg_idx_e idx, input logic [TEMP_BITS-1:0] data);
    cfg_we_i   <= 1'b1;
    cfg_idx_i  <= idx;
    cfg_data_i <= data;
    @(posedge clk_i);
    case (idx)
      CFG_MARGIN: hyst_margin = data[MARGIN_W-1:0];
      CFG_AUTO:   auto_mode   = data[0];
      default:    room_target[int'(idx)] = temp_t'(data);
    endcase
  endtask

  // Write every register, block idle
  task automatic apply_setting(input int unsigned margin_val, input bit auto_val);
    drain_results();
    for (int r = 0; r < ROOMS; r++) cfg_write(cfg_idx_e'(CFG_TARGET_0 + r), staged_target[r]);
    cfg_write(CFG_MARGIN, margin_val[TEMP_BITS-1:0]);
    cfg_write(CFG_AUTO, {{(TEMP_BITS-1){1'b0}}, auto_val});
    cfg_we_i <= 1'b0;
    settings_applied++;
  endtask

  task automatic stage_all_targets(input int value);
    for (int r = 0; r < ROOMS; r++) staged_target[r] = temp_t'(value);
  endtask

  // Out of reset automatic mode is off, so radiators stay off
  task automatic test_hold_after_reset();
    send_request(make_tick());
    send_request(make_sample(0, 100));
    send_request(make_sample(3, 5));
  endtask

  // Switching thresholds, sample window edges and ignored rooms
  task automatic test_directed_switching();
    stage_all_targets(TARGET_RESET);
    apply_setting(MARGIN_RESET, 1'b1);
    send_request(make_tick());          // every room at or below target: all on
    send_request(make_sample(0, 337));  // just above target plus margin: off
    send_request(make_sample(1, 336));  // exactly target plus margin: stays on
    send_request(make_sample(2, 799));  // top of window
    send_request(make_sample(3, 800));  // window upper bound, rejected
    send_request(make_sample(4, 0));    // window lower bound, rejected
    send_request(make_sample(5, 1));    // bottom of window
    send_request(make_sample(6, 400));  // room outside range
    send_request(make_sample(7, 400));
    send_request(make_sample(0, -2048));
    send_request(make_sample(0, 2047));
    send_request(make_sample(0, -1));
    send_request(make_sample(0, 320));  // back to target: on again
    send_request(make_sample(2, 321));  // off and above target: stays off
    send_request(make_tick());
  endtask

  // Lowest and highest targets, zero and widest margin
  task automatic test_setting_extremes();
    stage_all_targets(-880);
    apply_setting(0, 1'b1);
    send_request(make_sample(1, 1));
    send_request(make_tick());
    stage_all_targets(2000);
    apply_setting(320, 1'b1);
    send_request(make_sample(4, 799));
    send_request(make_tick());
    stage_all_targets(1);
    apply_setting(0, 1'b1);
    send_request(make_sample(5, 2));
    send_request(make_sample(5, 1));
  endtask

  // Back-to-back ticks with the odd sample; the counters advance and samples leave them alone
  task automatic test_tick_run();
    send_idling  = 1'b0;
    stall_idling = 1'b0;
    for (int unsigned n = 0; n < TICK_RUN; n++) begin
      if (n % 13 == 5) send_request(make_sample(n % ROOMS, int'((n * 23) % 900)));
      else send_request(make_tick());
    end
    send_idling  = 1'b1;
    stall_idling = 1'b1;
  endtask

  // Random requests across a sweep of settings
  task automatic test_random_settings();
    int unsigned margin_val;
    bit          auto_val;
    for (int p = 0; p < PHASES; p++) begin
      auto_val = 1'b1;
      case (p)
        0: begin stage_all_targets(-880); margin_val = 0; end
        1: begin stage_all_targets(2000); margin_val = 320; end
        2: begin
          for (int r = 0; r < ROOMS; r++) staged_target[r] = temp_t'($urandom_range(0, 800));
          margin_val = $urandom_range(0, 64);
        end
        3: begin
          // automatic mode off: radiators hold
          for (int r = 0; r < ROOMS; r++) staged_target[r] = temp_t'($urandom_range(0, 800));
          margin_val = $urandom_range(0, 320);
          auto_val   = 1'b0;
        end
        4: begin
          for (int r = 0; r < ROOMS; r++) staged_target[r] = temp_t'($urandom_range(0, 2880) - 880);
          margin_val = $urandom_range(0, 320);
        end
        default: begin
          for (int r = 0; r < ROOMS; r++) staged_target[r] = temp_t'($urandom_range(200, 600));
          margin_val = $urandom_range(0, 8);
        end
      endcase
      apply_setting(margin_val, auto_val);
      // stretches with no idling on either side
      send_idling  = (p != 4);
      stall_idling = (p != 4);
      for (int i = 0; i < PHASE_ITEMS; i++) begin
        if (p == 2 && i == PHASE_ITEMS / 2) drain_results();
        send_request(random_request());
      end
    end
    send_idling  = 1'b1;
    stall_idling = 1'b1;
  endtask

  // Receiver stall pattern: alternating runs of random length
  always @(posedge clk_i) begin
    if (!rst_ni || !stall_idling) begin
      stall_now = 1'b0;
      stall_run = 0;
    end else if (stall_run == 0) begin
      stall_now = ~stall_now;
      stall_run = stall_now ? $urandom_range(1, 5) : $urandom_range(1, 9);
    end else begin
      stall_run--;
    end
    out_stall_i <= stall_now;
  end

  task automatic note_mismatch(input string what, input int want, input int got);
    if (mismatch_count < 10)
      $display("%0t: %s mismatch: expected %0d, got %0d", $realtime, what, want, got);
    mismatch_count++;
  endtask

  // Result checker
  always @(posedge clk_i) begin
    out_item_t want;
    if (rst_ni && out_valid_o && !out_stall_i) begin
      if (expected_results.size() == 0) begin
        if (mismatch_count < 10)
          $display("%0t: result with nothing outstanding: %h", $realtime, out_data_o);
        mismatch_count++;
      end else begin
        want = expected_results.pop_front();
        if (out_data_o.radiator_mask !== want.radiator_mask)
          note_mismatch("radiator_mask", want.radiator_mask, out_data_o.radiator_mask);
        if (out_data_o.read_request !== want.read_request)
          note_mismatch("read_request", want.read_request, out_data_o.read_request);
        if (out_data_o.sample_accepted !== want.sample_accepted)
          note_mismatch("sample_accepted", want.sample_accepted, out_data_o.sample_accepted);
      end
    end
  end

  // Watchdog on handshake activity
  always @(posedge clk_i) begin
    if (rst_ni) begin
      if ((in_valid_i && !in_stall_o) || (out_valid_o && !out_stall_i)) quiet_cycles <= 0;
      else quiet_cycles <= quiet_cycles + 1;
      if (quiet_cycles >= QUIET_LIMIT) begin
        $display("%0t: no handshake for %0d cycles, %0d results outstanding",
                 $realtime, quiet_cycles, expected_results.size());
        $display("multi_room_hysteresis_thermostat verification failed");
        $finish;
      end
    end
  end

  // Test sequence
  initial begin
    for (int r = 0; r < ROOMS; r++) begin
      room_target[r] = TARGET_RESET;
      stored_temp[r] = '0;
    end
    hyst_margin  = MARGIN_RESET;
    auto_mode    = 1'b0;
    fast_cnt     = 0;
    slow_cnt     = 0;
    heat_on      = '0;
    send_idling  = 1'b1;
    stall_idling = 1'b1;
    burst_left   = 0;
    quiet_cycles = 0;

    repeat (7) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);

    test_hold_after_reset();
    test_directed_switching();
    test_setting_extremes();
    test_tick_run();
    test_random_settings();

    drain_results();
    repeat (4) @(posedge clk_i);
    $display("covered %0d requests over %0d settings: %0d samples stored, %0d read requests",
             requests_sent, settings_applied, samples_stored, read_requests_seen);
    $display("%0d radiator switch events, with sender gaps and receiver stalls",
             radiator_switches);
    if (mismatch_count == 0) begin
      $display("multi_room_hysteresis_thermostat verification clean");
    end else begin
      $display("%0d mismatches", mismatch_count);
      $display("multi_room_hysteresis_thermostat verification failed");
    end
    $finish;
  end

endmodule

/* files.f */
hw/rtl/mrht_pkg.sv
hw/rtl/mrht_timer.sv
hw/rtl/mrht_rooms.sv
hw/rtl/multi_room_hysteresis_thermostat.sv
tb/sv/multi_room_hysteresis_thermostat_tb.sv
